### design/ccd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types and constants of the chunked container deframer.
// ----------------------------------------------------------------------------
package ccd_pkg;
  localparam int MAX_CHUNKS = 256;
  localparam int TBL_AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int TBL_DW = 64;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_ENC = 3'd2;
  localparam logic [2:0] KIND_ERROR = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  localparam logic [3:0] ERR_MAGIC = 4'd0;
  localparam logic [3:0] ERR_SHORT = 4'd1;
  localparam logic [3:0] ERR_FORMAT = 4'd2;
  localparam logic [3:0] ERR_COUNT = 4'd3;
  localparam logic [3:0] ERR_MODE = 4'd4;
  localparam logic [3:0] ERR_FRAME = 4'd5;
  localparam logic [3:0] ERR_KEYSIZE = 4'd6;
  localparam logic [3:0] ERR_IVSIZE = 4'd7;
  localparam logic [3:0] ERR_ENCTYPE = 4'd8;
  localparam logic [3:0] ERR_ARC4 = 4'd9;
  localparam logic [3:0] ERR_NOSIZE = 4'd10;
  localparam logic [3:0] ERR_EARLY = 4'd11;

  localparam logic [1:0] MODE_N = 2'd0;
  localparam logic [1:0] MODE_Z = 2'd1;
  localparam logic [1:0] MODE_E = 2'd2;

  typedef enum logic [12:0] {
    PH_MAGIC = 13'h0001, PH_HSIZE = 13'h0002, PH_FMT = 13'h0004,
    PH_COUNT = 13'h0008, PH_TABLE = 13'h0010, PH_MODE = 13'h0020,
    PH_EKSZ = 13'h0040, PH_EKEY = 13'h0080, PH_EIVSZ = 13'h0100,
    PH_EIV = 13'h0200, PH_ETYPE = 13'h0400, PH_DATA = 13'h0800,
    PH_IDLE = 13'h1000
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic [23:0] chunk_number;
    logic [1:0] chunk_mode;
    logic [31:0] decoded_size;
    logic [63:0] key_name;
    logic [31:0] iv_word;
    logic [3:0] error_code;
    logic last;
  } result_t;
endpackage

### design/ccd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ccd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

### design/ccd_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_outq
// Four-entry result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module ccd_outq (
  input  logic clk,
  input  logic rst_n,
  input  logic push0,
  input  logic push1,
  input  ccd_pkg::result_t data0,
  input  ccd_pkg::result_t data1,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output ccd_pkg::result_t head
);
  import ccd_pkg::*;

  result_t q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic pop;
  logic [1:0] n_push;

  assign pop = out_valid && out_ready;
  assign out_valid = cnt_r != 3'd0;
  assign head = q_r[rp_r];
  assign n_push = {1'b0, push0} + {1'b0, push1};
  // Room for two more results, without counting a pop this cycle.
  assign space = cnt_r <= 3'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push0) q_r[wp_r] <= data0;
      if (push1) q_r[push0 ? wp_r + 2'd1 : wp_r] <= data1;
      wp_r <= wp_r + n_push;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, n_push} - {2'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push0 || push1) |-> cnt_r <= 3'd3) else $error("push without room");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 3'd0) else $error("pop from empty queue");
`endif
endmodule

### design/ccd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccd_parser
// Header and chunk parser. Table entries live in a RAM read one byte early.
// ----------------------------------------------------------------------------
module ccd_parser (
  input  logic clk,
  input  logic rst_n,
  input  logic take,
  input  logic [7:0] b,
  input  logic stream_end,
  input  logic [31:0] expected_size,
  output logic push0,
  output logic push1,
  output ccd_pkg::result_t data0,
  output ccd_pkg::result_t data1
);
  import ccd_pkg::*;

  phase_t ph_r, ph_nxt;
  logic [31:0] fc_r, fc_nxt, hl_r, hl_nxt;
  logic [23:0] tot_r, tot_nxt, cur_r, cur_nxt;
  logic [63:0] key_r, key_nxt, ent_r, ent_nxt;
  logic [31:0] iv_r, iv_nxt, dec_r, dec_nxt;
  logic sb_r, sb_nxt;
  logic [3:0] sub_r, sub_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [4:0] j_r, j_nxt;
  logic [23:0] e_r, e_nxt;
  logic [1:0] mi;
  logic [7:0] magic;

  logic wr_en;
  logic [TBL_AW-1:0] rd_addr;
  logic [63:0] rd_data, ent_rd;
  logic [24:0] cur_inc;
  logic cur_ok;

  ccd_ram #(.WIDTH(TBL_DW), .DEPTH(MAX_CHUNKS)) u_tbl (
    .clk(clk), .wr_en(wr_en), .wr_addr(e_r[TBL_AW-1:0]), .wr_data(ent_nxt),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // The entry for the next chunk is read while the current one streams,
  // so the mode byte sees it registered.
  assign rd_addr = cur_nxt[TBL_AW-1:0];
  assign cur_ok = cur_r < 24'(MAX_CHUNKS);
  assign ent_rd = cur_ok ? rd_data : 64'd0;

  always_comb begin
    mi = fc_r[1:0];
    case (mi)
      2'd0: magic = 8'h42;
      2'd1: magic = 8'h4C;
      2'd2: magic = 8'h54;
      default: magic = 8'h45;
    endcase
  end

  function automatic result_t mk(input logic [2:0] k, input logic [7:0] p,
      input logic [23:0] cn, input logic [1:0] md, input logic [31:0] ds,
      input logic [63:0] ky, input logic [31:0] iv, input logic [3:0] er);
    result_t r;
    r.kind = k;
    r.payload_byte = p;
    r.chunk_number = (k <= KIND_ENC) ? cn : 24'd0;
    r.chunk_mode = (k <= KIND_ENC) ? md : 2'd0;
    r.decoded_size = (k <= KIND_ENC) ? ds : 32'd0;
    r.key_name = ky;
    r.iv_word = iv;
    r.error_code = er;
    r.last = (k == KIND_ERROR) || (k == KIND_DONE);
    return r;
  endfunction

  always_comb begin
    logic [1:0] n;
    logic [2:0] k0, k1;
    logic [7:0] p0;
    logic [3:0] er0, er1;
    logic [63:0] ky0;
    logic [31:0] iv0;
    logic [31:0] comp;
    logic [1:0] m;
    logic [1:0] md_o;
    logic [31:0] ds_o;
    n = 2'd0;
    k0 = KIND_PAYLOAD; k1 = KIND_PAYLOAD;
    p0 = 8'd0; er0 = 4'd0; er1 = 4'd0; ky0 = 64'd0; iv0 = 32'd0;
    comp = 32'd0; m = MODE_N;
    md_o = mode_r; ds_o = dec_r;
    ph_nxt = ph_r; fc_nxt = fc_r; hl_nxt = hl_r; tot_nxt = tot_r; cur_nxt = cur_r;
    key_nxt = key_r; iv_nxt = iv_r; dec_nxt = dec_r; sb_nxt = sb_r;
    sub_nxt = sub_r; mode_nxt = mode_r; j_nxt = j_r; e_nxt = e_r;
    ent_nxt = {ent_r[55:0], b};
    wr_en = 1'b0;
    cur_inc = {1'b0, cur_r} + 25'd1;
    if (take) begin
      case (ph_r)
        PH_MAGIC: begin
          if (b != magic) begin
            n = 2'd1; k0 = KIND_ERROR; er0 = ERR_MAGIC; ph_nxt = PH_IDLE;
          end else begin
            fc_nxt = fc_r + 32'd1;
            if (fc_r[1:0] == 2'd3) ph_nxt = PH_HSIZE;
          end
        end
        PH_HSIZE: begin
          hl_nxt = {hl_r[23:0], b};
          fc_nxt = fc_r + 32'd1;
          if (fc_r == 32'd7) begin
            if (hl_nxt == 32'd0) begin
              sb_nxt = 1'b1; cur_nxt = 24'd0; ph_nxt = PH_MODE;
            end else ph_nxt = PH_FMT;
          end
        end
        PH_FMT: begin
          if (b != 8'h0F) begin
            n = 2'd1; k0 = KIND_ERROR; er0 = ERR_FORMAT; ph_nxt = PH_IDLE;
          end else begin
            fc_nxt = fc_r + 32'd1; ph_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          tot_nxt = {tot_r[15:0], b};
          fc_nxt = fc_r + 32'd1;
          j_nxt = 5'd0; e_nxt = 24'd0;
          if (fc_r == 32'd11) begin
            if (tot_nxt > 24'(MAX_CHUNKS)) begin
              n = 2'd1; k0 = KIND_ERROR; er0 = ERR_COUNT; ph_nxt = PH_IDLE;
            end else if ({4'd0, hl_r} < 36'd12 + 36'(tot_nxt) * 36'd24) begin
              n = 2'd1; k0 = KIND_ERROR; er0 = ERR_SHORT; ph_nxt = PH_IDLE;
            end else begin
              ph_nxt = PH_TABLE;
              if (hl_r == 32'd12) begin
                cur_nxt = 24'd0;
                if (tot_nxt == 24'd0) begin
                  n = 2'd1; k0 = KIND_DONE; ph_nxt = PH_IDLE;
                end else ph_nxt = PH_MODE;
              end
            end
          end
        end
        PH_TABLE: begin
          if (j_r == 5'd0) ent_nxt = {56'd0, b};
          if (e_r < tot_r && j_r == 5'd7) wr_en = 1'b1;
          if (j_r == 5'd23) begin
            j_nxt = 5'd0;
            if (e_r < tot_r) e_nxt = e_r + 24'd1;
          end else j_nxt = j_r + 5'd1;
          fc_nxt = fc_r + 32'd1;
          if (fc_nxt == hl_r) begin
            cur_nxt = 24'd0;
            if (tot_r == 24'd0) begin
              n = 2'd1; k0 = KIND_DONE; ph_nxt = PH_IDLE;
            end else ph_nxt = PH_MODE;
          end
        end
        PH_MODE: begin
          case (b)
            8'h4E: m = MODE_N;
            8'h5A: m = MODE_Z;
            default: m = MODE_E;
          endcase
          comp = ent_rd[63:32];
          if (!sb_r && comp == 32'd0) begin
            n = 2'd1; k0 = KIND_ERROR; er0 = ERR_SHORT; ph_nxt = PH_IDLE;
          end else if (sb_r && b != 8'h4E && expected_size == 32'd0) begin
            n = 2'd1; k0 = KIND_ERROR; er0 = ERR_NOSIZE; ph_nxt = PH_IDLE;
          end else begin
            dec_nxt = sb_r ? expected_size : ent_rd[31:0];
            fc_nxt = sb_r ? 32'd0 : comp - 32'd1;
            if (b == 8'h46) begin
              n = 2'd1; k0 = KIND_ERROR; er0 = ERR_FRAME; ph_nxt = PH_IDLE;
            end else if (b != 8'h4E && b != 8'h5A && b != 8'h45) begin
              n = 2'd1; k0 = KIND_ERROR; er0 = ERR_MODE; ph_nxt = PH_IDLE;
            end else begin
              mode_nxt = m;
              n = 2'd1; k0 = KIND_START;
              if (m == MODE_E) begin
                if (!sb_r && fc_nxt == 32'd0) begin
                  n = 2'd2; k1 = KIND_ERROR; er1 = ERR_SHORT; ph_nxt = PH_IDLE;
                end else ph_nxt = PH_EKSZ;
              end else begin
                ph_nxt = PH_DATA;
                if (!sb_r && fc_nxt == 32'd0) begin
                  cur_nxt = cur_inc[23:0];
                  if (cur_inc[23:0] >= tot_r) begin
                    n = 2'd2; k1 = KIND_DONE; ph_nxt = PH_IDLE;
                  end else ph_nxt = PH_MODE;
                end
              end
            end
          end
        end
        PH_EKSZ: begin
          if (!sb_r) fc_nxt = fc_r - 32'd1;
          if (b != 8'd8) begin
            n = 2'd1; k0 = KIND_ERROR; er0 = ERR_KEYSIZE; ph_nxt = PH_IDLE;
          end else if (!sb_r && fc_nxt < 32'd9) begin
            n = 2'd1; k0 = KIND_ERROR; er0 = ERR_SHORT; ph_nxt = PH_IDLE;
          end else begin
            key_nxt = 64'd0; sub_nxt = 4'd0; ph_nxt = PH_EKEY;
          end
        end
        PH_EKEY: begin
          if (!sb_r) fc_nxt = fc_r - 32'd1;
          key_nxt = key_r | ({56'd0, b} << {sub_r[2:0], 3'b000});
          sub_nxt = sub_r + 4'd1;
          if (sub_r == 4'd7) ph_nxt = PH_EIVSZ;
        end
        PH_EIVSZ: begin
          if (!sb_r) fc_nxt = fc_r - 32'd1;
          if (b != 8'd4) begin
            n = 2'd1; k0 = KIND_ERROR; er0 = ERR_IVSIZE; ph_nxt = PH_IDLE;
          end else if (!sb_r && fc_nxt < 32'd5) begin
            n = 2'd1; k0 = KIND_ERROR; er0 = ERR_SHORT; ph_nxt = PH_IDLE;
          end else begin
            iv_nxt = 32'd0; sub_nxt = 4'd0; ph_nxt = PH_EIV;
          end
        end
        PH_EIV: begin
          if (!sb_r) fc_nxt = fc_r - 32'd1;
          iv_nxt = iv_r | ({24'd0, b} << {sub_r[1:0], 3'b000});
          sub_nxt = sub_r + 4'd1;
          if (sub_r == 4'd3) ph_nxt = PH_ETYPE;
        end
        PH_ETYPE: begin
          if (!sb_r) fc_nxt = fc_r - 32'd1;
          if (b == 8'h53) begin
            n = 2'd1; k0 = KIND_ENC; ky0 = key_r; iv0 = iv_r ^ {8'd0, cur_r};
            ph_nxt = PH_DATA;
            if (!sb_r && fc_nxt == 32'd0) begin
              cur_nxt = cur_inc[23:0];
              if (cur_inc[23:0] >= tot_r) begin
                n = 2'd2; k1 = KIND_DONE; ph_nxt = PH_IDLE;
              end else ph_nxt = PH_MODE;
            end
          end else begin
            n = 2'd1; k0 = KIND_ERROR; ph_nxt = PH_IDLE;
            er0 = (b == 8'h41) ? ERR_ARC4 : ERR_ENCTYPE;
          end
        end
        PH_DATA: begin
          n = 2'd1; k0 = KIND_PAYLOAD; p0 = b;
          if (!sb_r) begin
            fc_nxt = fc_r - 32'd1;
            if (fc_nxt == 32'd0) begin
              cur_nxt = cur_inc[23:0];
              if (cur_inc[23:0] >= tot_r) begin
                n = 2'd2; k1 = KIND_DONE; ph_nxt = PH_IDLE;
              end else ph_nxt = PH_MODE;
            end
          end
        end
        default: ;
      endcase
      md_o = mode_nxt;
      ds_o = dec_nxt;
      if (stream_end) begin
        if (ph_nxt != PH_IDLE) begin
          if (n == 2'd0) k0 = KIND_ERROR; else k1 = KIND_ERROR;
          if (sb_nxt && ph_nxt == PH_DATA) begin
            if (n == 2'd0) k0 = KIND_DONE; else k1 = KIND_DONE;
          end else if (sb_nxt && (ph_nxt == PH_EKSZ || ph_nxt == PH_EKEY ||
              ph_nxt == PH_EIVSZ || ph_nxt == PH_EIV || ph_nxt == PH_ETYPE)) begin
            if (n == 2'd0) er0 = ERR_SHORT; else er1 = ERR_SHORT;
          end else begin
            if (n == 2'd0) er0 = ERR_EARLY; else er1 = ERR_EARLY;
          end
          n = n + 2'd1;
        end
        ph_nxt = PH_MAGIC; fc_nxt = 32'd0; hl_nxt = 32'd0; tot_nxt = 24'd0;
        cur_nxt = 24'd0; key_nxt = 64'd0; iv_nxt = 32'd0; sb_nxt = 1'b0;
        sub_nxt = 4'd0; mode_nxt = MODE_N; dec_nxt = 32'd0;
      end
    end
    push0 = n != 2'd0;
    push1 = n == 2'd2;
    data0 = mk(k0, p0, cur_r, md_o, ds_o, ky0, iv0, er0);
    data1 = mk(k1, 8'd0, cur_r, md_o, ds_o, 64'd0, 32'd0, er1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_MAGIC;
      fc_r <= '0; hl_r <= '0; tot_r <= '0; cur_r <= '0;
      key_r <= '0; iv_r <= '0; sb_r <= 1'b0; sub_r <= '0;
      mode_r <= MODE_N; dec_r <= '0; j_r <= '0; e_r <= '0;
    end else begin
      ph_r <= ph_nxt;
      fc_r <= fc_nxt; hl_r <= hl_nxt; tot_r <= tot_nxt; cur_r <= cur_nxt;
      key_r <= key_nxt; iv_r <= iv_nxt; sb_r <= sb_nxt; sub_r <= sub_nxt;
      mode_r <= mode_nxt; dec_r <= dec_nxt; j_r <= j_nxt; e_r <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) ent_r <= ent_nxt;
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(ph_r)) else $error("phase not one-hot");
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> push0) else $error("second result without first");
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && stream_end) |=> ph_r == PH_MAGIC) else $error("no restart at end");
  a_write_table: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ph_r == PH_TABLE) else $error("table write outside table");
`endif
endmodule

### design/chunked_container_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_container_deframer
// Parses a chunked container byte stream and reports chunks and payload.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_      in         stream_byte, stream_end
//  out_     out        kind .. last, one result per transaction
//  cfg_     in         expected_size
// One input byte is accepted per cycle while the result queue has room for
// two results; a byte yields at most two, drained one per out_ready cycle.
// The chunk size table is a registered-read RAM addressed ahead of each mode byte.
// Reset is synchronous; the size table needs no clearing pass.
// A stalled output lowers in_ready once the four-entry queue holds three.
module chunked_container_deframer (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_stream_byte,
  input  logic in_stream_end,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [31:0] cfg_expected_size,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_payload_byte,
  output logic [23:0] out_chunk_number,
  output logic [1:0] out_chunk_mode,
  output logic [31:0] out_decoded_size,
  output logic [63:0] out_key_name,
  output logic [31:0] out_iv_word,
  output logic [3:0] out_error_code,
  output logic out_last
);
  import ccd_pkg::*;

  logic [31:0] exp_r;
  logic take, push0, push1, space;
  result_t d0, d1, head;

  assign cfg_ready = 1'b1;
  assign in_ready = space;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) exp_r <= '0;
    else if (cfg_valid) exp_r <= cfg_expected_size;
  end

  ccd_parser u_parser (
    .clk(clk), .rst_n(rst_n), .take(take), .b(in_stream_byte),
    .stream_end(in_stream_end), .expected_size(exp_r),
    .push0(push0), .push1(push1), .data0(d0), .data1(d1)
  );

  ccd_outq u_outq (
    .clk(clk), .rst_n(rst_n), .push0(push0), .push1(push1),
    .data0(d0), .data1(d1), .space(space),
    .out_valid(out_valid), .out_ready(out_ready), .head(head)
  );

  assign out_kind = head.kind;
  assign out_payload_byte = head.payload_byte;
  assign out_chunk_number = head.chunk_number;
  assign out_chunk_mode = head.chunk_mode;
  assign out_decoded_size = head.decoded_size;
  assign out_key_name = head.key_name;
  assign out_iv_word = head.iv_word;
  assign out_error_code = head.error_code;
  assign out_last = head.last;
endmodule
